/* src/msts_pkg.sv */
// Shared types and codes for the multi-slot timeout scheduler.
package msts_pkg;

    // Command codes carried on the slave-side tuser
    localparam logic [1:0] CMD_ARM    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;

    // Result kinds carried on the master-side tuser
    localparam logic [1:0] KIND_ARM    = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_FULL       = 2'd1;
    localparam logic [1:0] ST_BADHANDLE  = 2'd2;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int TAG_W    = 32;
    localparam int HANDLE_W = 8;
    localparam int IN_DW    = 112;  // 105 field bits padded to whole bytes
    localparam int OUT_DW   = 48;   // 42 field bits padded to whole bytes

    // One slot entry as held in the slot RAM
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              once;
        logic [TIME_W-1:0] last_run;
        logic [TIME_W-1:0] period;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARM,
        ST_CANCEL,
        ST_TICK_RD,
        ST_TICK_CHK,
        ST_DONE
    } t_state;

endpackage

/* src/msts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module msts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/multi_slot_timeout_scheduler_top.sv */
// Timer slot table: arm, cancel and tick-scan sequencer around one slot RAM.
//
//  channel  | dir | tuser       | tdata (low bit up)                          | tlast
//  ---------+-----+-------------+---------------------------------------------+------
//  s (cmd)  | in  | cmd [1:0]   | now_ms, period_ms, one_shot, callback_tag,  | -
//           |     |             | handle_in, zero pad to 112                  |
//  m (res)  | out | kind [1:0]  | status, handle_out, tag_out, zero pad to 48 | last
//
//  Sequence: arm scans upward from slot 0 for the lowest free slot and reports
//  full when none is free; cancel clears the flag of its handle; tick skips
//  free slots, reads and checks each armed slot, then sends the done beat.
//  The slot RAM read port and the shared elapsed-time subtract/compare set
//  the per-slot cost. Reset clears the valid flags; there is no clearing
//  pass. A stalled master side holds the sequencer, when it has a beat to
//  send, for as long as the waiting beat stays unaccepted.
module multi_slot_timeout_scheduler_top #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave side
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [msts_pkg::IN_DW-1:0]    i_s_tdata,   // now_ms, period_ms, one_shot,
                                                       // callback_tag, handle_in
    input  logic [1:0]                    i_s_tuser,   // cmd
    // master side
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [msts_pkg::OUT_DW-1:0]   o_m_tdata,   // status, handle_out, tag_out
    output logic [1:0]                    o_m_tuser,   // kind
    output logic                          o_m_tlast    // last
);

    import msts_pkg::*;

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // Sequencer and table state
    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [NUM_SLOTS-1:0]  r_valid, n_valid;

    // Latched command operands
    logic [TIME_W-1:0]     r_now;
    logic [TIME_W-1:0]     r_period;
    logic                  r_once;
    logic [TAG_W-1:0]      r_tag;
    logic [HANDLE_W-1:0]   r_handle;

    // Output register
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_out_kind, n_out_kind;
    logic [1:0]            r_out_status, n_out_status;
    logic [HANDLE_W-1:0]   r_out_handle, n_out_handle;
    logic [TAG_W-1:0]      r_out_tag, n_out_tag;
    logic                  r_out_last, n_out_last;

    // RAM port and shared compare unit
    logic                  w_we, w_re;
    t_slot                 w_wdata, w_rd;
    logic [TIME_W-1:0]     w_elapsed;
    logic                  w_due;
    logic                  w_accept, w_out_free, w_bad_handle;
    logic [HANDLE_W-1:0]   w_handle_m1;
    logic [IDX_W-1:0]      w_cancel_idx;
    logic [HANDLE_W-1:0]   w_idx_handle;

    assign o_s_tready   = (r_state == ST_IDLE);
    assign w_accept     = i_s_tvalid && o_s_tready;
    assign w_out_free   = !r_out_valid || i_m_tready;
    assign w_elapsed    = r_now - w_rd.last_run;
    assign w_due        = (w_elapsed >= w_rd.period);
    assign w_bad_handle = (r_handle == '0) || (r_handle > HANDLE_W'(NUM_SLOTS));
    assign w_handle_m1  = r_handle - HANDLE_W'(1);
    assign w_cancel_idx = w_handle_m1[IDX_W-1:0];
    assign w_idx_handle = HANDLE_W'(r_idx) + HANDLE_W'(1);

    // Slot RAM: period, last run, one-shot flag and tag per slot
    msts_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_idx),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rd)
    );

    // State, index, valid flags and output handshake control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Operand capture and output payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now    <= i_s_tdata[31:0];
            r_period <= i_s_tdata[63:32];
            r_once   <= i_s_tdata[64];
            r_tag    <= i_s_tdata[96:65];
            r_handle <= i_s_tdata[104:97];
        end
        r_out_kind   <= n_out_kind;
        r_out_status <= n_out_status;
        r_out_handle <= n_out_handle;
        r_out_tag    <= n_out_tag;
        r_out_last   <= n_out_last;
    end

    // Sequencer: next state, table updates and result beats
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_valid      = r_valid;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_kind   = r_out_kind;
        n_out_status = r_out_status;
        n_out_handle = r_out_handle;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_wdata      = w_rd;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx = '0;
                    case (i_s_tuser)
                        CMD_ARM:    n_state = ST_ARM;
                        CMD_CANCEL: n_state = ST_CANCEL;
                        CMD_TICK:   n_state = ST_TICK_RD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end

            // search for the lowest free slot, one per cycle
            ST_ARM: begin
                if (!r_valid[r_idx]) begin
                    if (w_out_free) begin
                        w_we             = 1'b1;
                        w_wdata.tag      = r_tag;
                        w_wdata.once     = r_once;
                        w_wdata.last_run = r_now;
                        w_wdata.period   = r_period;
                        n_valid[r_idx]   = 1'b1;
                        n_out_valid      = 1'b1;
                        n_out_kind       = KIND_ARM;
                        n_out_status     = ST_OK;
                        n_out_handle     = w_idx_handle;
                        n_out_tag        = '0;
                        n_out_last       = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else if (r_idx == LAST_IDX) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_ARM;
                        n_out_status = ST_FULL;
                        n_out_handle = '0;
                        n_out_tag    = '0;
                        n_out_last   = 1'b1;
                        n_state      = ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            ST_CANCEL: begin
                if (w_out_free) begin
                    if (!w_bad_handle) begin
                        n_valid[w_cancel_idx] = 1'b0;
                    end
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_CANCEL;
                    n_out_status = w_bad_handle ? ST_BADHANDLE : ST_OK;
                    n_out_handle = r_handle;
                    n_out_tag    = '0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            // skip free slots, fetch armed ones
            ST_TICK_RD: begin
                if (r_valid[r_idx]) begin
                    w_re    = 1'b1;
                    n_state = ST_TICK_CHK;
                end else if (r_idx == LAST_IDX) begin
                    n_state = ST_DONE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // elapsed-time check; fire and update when due
            ST_TICK_CHK: begin
                if (!w_due || w_out_free) begin
                    if (w_due) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = KIND_FIRE;
                        n_out_status = ST_OK;
                        n_out_handle = w_idx_handle;
                        n_out_tag    = w_rd.tag;
                        n_out_last   = 1'b0;
                        if (w_rd.once) begin
                            n_valid[r_idx] = 1'b0;
                        end else begin
                            w_we             = 1'b1;
                            w_wdata.last_run = r_now;
                        end
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = ST_DONE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = ST_TICK_RD;
                    end
                end
            end

            ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = KIND_DONE;
                    n_out_status = ST_OK;
                    n_out_handle = '0;
                    n_out_tag    = '0;
                    n_out_last   = 1'b1;
                    n_state      = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // Master-side outputs
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_kind;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {6'd0, r_out_tag, r_out_handle, r_out_status};

    // Fire beats never close an item
    a_fire_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_FIRE) |-> !r_out_last)
        else $error("fire beat marked last");

    // A successful arm always hands out an in-range handle
    a_arm_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind == KIND_ARM && r_out_status == ST_OK)
        |-> (r_out_handle != '0 && r_out_handle <= HANDLE_W'(NUM_SLOTS)))
        else $error("arm handle out of range");

    // At most one slot gets armed per cycle
    a_one_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ($countones(r_valid) <= $countones($past(r_valid)) + 1))
        else $error("more than one slot armed at once");

    // Slot flags change only while a command is in progress
    a_idle_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> $stable(r_valid))
        else $error("slot flags changed while idle");

endmodule

/* tb/tb.sv */
// Testbench for the timer slot table: directed command table, then random commands.
`timescale 1ns / 1ps

module tb;
    import msts_pkg::*;

    localparam int SLOTS       = 16;
    localparam int RAND_ITEMS  = 330;
    localparam int TAIL_CYCLES = 2 * SLOTS + 8;

    // cmd code the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // One command beat, unpacked from slave-side tdata/tuser
    typedef struct packed {
        logic [1:0]          cmd;
        logic [TIME_W-1:0]   now_ms;
        logic [TIME_W-1:0]   period_ms;
        logic                one_shot;
        logic [TAG_W-1:0]    tag;
        logic [HANDLE_W-1:0] handle;
    } t_cmd_beat;

    // One result beat, unpacked from master-side tdata/tuser/tlast
    typedef struct packed {
        logic [1:0]          kind;
        logic [1:0]          status;
        logic [HANDLE_W-1:0] handle;
        logic [TAG_W-1:0]    tag;
        logic                last;
    } t_res;

    // Directed row: expected result typed in only when typed is set
    typedef struct {
        t_cmd_beat beat;
        int        reps;
        bit        typed;
        int        n_typed;
        t_res      want;
    } t_dir_row;

    localparam t_res NO_RES = '0;

    // DUT ports
    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    wire                 o_s_tready;
    logic [IN_DW-1:0]    i_s_tdata  = '0;   // now_ms, period_ms, one_shot, callback_tag, handle_in
    logic [1:0]          i_s_tuser  = '0;   // cmd
    wire                 o_m_tvalid;
    logic                i_m_tready = 1'b0;
    wire  [OUT_DW-1:0]   o_m_tdata;         // status, handle_out, tag_out
    wire  [1:0]          o_m_tuser;         // kind
    wire                 o_m_tlast;         // last

    // Slot table mirror
    logic                slot_used   [SLOTS];
    logic [TIME_W-1:0]   slot_per    [SLOTS];
    logic [TIME_W-1:0]   slot_start  [SLOTS];
    logic                slot_single [SLOTS];
    logic [TAG_W-1:0]    slot_cb_tag [SLOTS];

    t_res      step_results[$];
    t_res      pending_results[$];
    t_dir_row  dir_rows[$];

    int                  err_cnt     = 0;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    logic [TIME_W-1:0]   tick_ms;

    multi_slot_timeout_scheduler_top #(
        .NUM_SLOTS(SLOTS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_res res_beat(logic [1:0] kind, logic [1:0] status,
                                      logic [HANDLE_W-1:0] handle, logic [TAG_W-1:0] tag,
                                      logic last);
        t_res r;
        r.kind   = kind;
        r.status = status;
        r.handle = handle;
        r.tag    = tag;
        r.last   = last;
        return r;
    endfunction

    // Apply one command to the slot mirror; results land in step_results
    function automatic void timer_table_step(t_cmd_beat b);
        int                i;
        int                free_idx;
        logic [TIME_W-1:0] elapsed;
        step_results.delete();
        case (b.cmd)
            CMD_ARM: begin
                free_idx = -1;
                for (i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_used[i]) free_idx = i;
                end
                if (free_idx < 0) begin
                    step_results = {step_results,
                                    res_beat(KIND_ARM, ST_FULL, '0, '0, 1'b1)};
                end else begin
                    slot_used[free_idx]   = 1'b1;
                    slot_per[free_idx]    = b.period_ms;
                    slot_start[free_idx]  = b.now_ms;
                    slot_single[free_idx] = b.one_shot;
                    slot_cb_tag[free_idx] = b.tag;
                    step_results = {step_results,
                                    res_beat(KIND_ARM, ST_OK, HANDLE_W'(free_idx + 1),
                                             '0, 1'b1)};
                end
            end
            CMD_CANCEL: begin
                if (b.handle == 0 || b.handle > SLOTS) begin
                    step_results = {step_results,
                                    res_beat(KIND_CANCEL, ST_BADHANDLE, b.handle,
                                             '0, 1'b1)};
                end else begin
                    slot_used[b.handle - 1] = 1'b0;
                    step_results = {step_results,
                                    res_beat(KIND_CANCEL, ST_OK, b.handle, '0, 1'b1)};
                end
            end
            CMD_TICK: begin
                // scan low to high; due when modular elapsed time reaches the period
                for (i = 0; i < SLOTS; i++) begin
                    elapsed = b.now_ms - slot_start[i];
                    if (slot_used[i] && elapsed >= slot_per[i]) begin
                        step_results = {step_results,
                                        res_beat(KIND_FIRE, ST_OK, HANDLE_W'(i + 1),
                                                 slot_cb_tag[i], 1'b0)};
                        if (slot_single[i]) slot_used[i] = 1'b0;
                        else slot_start[i] = b.now_ms;
                    end
                end
                step_results = {step_results, res_beat(KIND_DONE, ST_OK, '0, '0, 1'b1)};
            end
            default: ;
        endcase
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [TIME_W-1:0] now_ms,
                                    logic [TIME_W-1:0] period_ms, logic one_shot,
                                    logic [TAG_W-1:0] tag, logic [HANDLE_W-1:0] handle,
                                    int reps, bit typed, int n_typed, t_res want);
        t_dir_row row;
        row.beat.cmd       = cmd;
        row.beat.now_ms    = now_ms;
        row.beat.period_ms = period_ms;
        row.beat.one_shot  = one_shot;
        row.beat.tag       = tag;
        row.beat.handle    = handle;
        row.reps           = reps;
        row.typed          = typed;
        row.n_typed        = n_typed;
        row.want           = want;
        dir_rows = {dir_rows, row};
    endfunction

    // Random command: mostly arm/cancel/tick on a running clock, a little noise
    function automatic t_cmd_beat rand_command();
        t_cmd_beat b;
        int        sel;
        b.now_ms    = $urandom;
        b.period_ms = $urandom;
        b.one_shot  = 1'($urandom_range(1));
        b.tag       = $urandom;
        b.handle    = HANDLE_W'($urandom_range(255));
        sel = $urandom_range(99);
        if (sel < 4) begin
            b.cmd = CMD_UNUSED;
        end else if (sel < 38) begin
            b.cmd = CMD_ARM;
            if ($urandom_range(9) != 0) b.now_ms = tick_ms;
            sel = $urandom_range(9);
            if (sel < 7) b.period_ms = $urandom_range(40);
            else if (sel == 7) b.period_ms = '0;
        end else if (sel < 58) begin
            b.cmd = CMD_CANCEL;
            if ($urandom_range(99) < 85) b.handle = HANDLE_W'($urandom_range(SLOTS, 1));
        end else begin
            b.cmd = CMD_TICK;
            if ($urandom_range(19) == 0) tick_ms += $urandom;
            else tick_ms += $urandom_range(12);
            b.now_ms = tick_ms;
        end
        return b;
    endfunction

    // Drive one command beat; tvalid stays high after acceptance
    task automatic post_command(t_cmd_beat b, bit typed, int n_typed, t_res want);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= b.cmd;
        i_s_tdata  <= IN_DW'({b.handle, b.tag, b.one_shot, b.period_ms, b.now_ms});
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        timer_table_step(b);
        if (typed) begin
            if (n_typed != 0) pending_results = {pending_results, want};
        end else begin
            foreach (step_results[k]) pending_results = {pending_results, step_results[k]};
        end
    endtask

    // Result side: check each accepted beat, then pick next tready
    initial begin
        t_res got;
        t_res want;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid === 1'b1 && i_m_tready) begin
                got = res_beat(o_m_tuser, o_m_tdata[1:0], o_m_tdata[9:2], o_m_tdata[41:10],
                               o_m_tlast);
                if (pending_results.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected result beat kind %0d status %0d handle %0d tag %h last %0b",
                             $time, got.kind, got.status, got.handle, got.tag, got.last);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        $display("%0t: mismatch expected kind %0d status %0d handle %0d tag %h last %0b",
                                 $time, want.kind, want.status, want.handle, want.tag, want.last);
                        $display("%0t:          actual   kind %0d status %0d handle %0d tag %h last %0b",
                                 $time, got.kind, got.status, got.handle, got.tag, got.last);
                    end
                end
            end
            i_m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

    // Stimulus
    initial begin
        t_cmd_beat b;
        int        n;
        foreach (slot_used[i]) slot_used[i] = 1'b0;

        // error codes, empty table, ignored code
        add_row(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 1, 1, 1,
                res_beat(KIND_CANCEL, ST_BADHANDLE, 8'd0, '0, 1'b1));
        add_row(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 32'd0, 8'hFF, 1, 1, 1,
                res_beat(KIND_CANCEL, ST_BADHANDLE, 8'hFF, '0, 1'b1));
        add_row(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 32'd0, 8'd17, 1, 1, 1,
                res_beat(KIND_CANCEL, ST_BADHANDLE, 8'd17, '0, 1'b1));
        add_row(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 32'd0, 8'd1, 1, 1, 1,
                res_beat(KIND_CANCEL, ST_OK, 8'd1, '0, 1'b1));
        add_row(CMD_TICK, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 1, 1, 1,
                res_beat(KIND_DONE, ST_OK, '0, '0, 1'b1));
        add_row(CMD_UNUSED, '1, '1, 1'b1, '1, '1, 1, 1, 0, NO_RES);
        // field extremes: zero period and tag, all-ones everything
        add_row(CMD_ARM, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 1, 1, 1,
                res_beat(KIND_ARM, ST_OK, 8'd1, '0, 1'b1));
        add_row(CMD_ARM, '1, '1, 1'b1, '1, '1, 1, 1, 1,
                res_beat(KIND_ARM, ST_OK, 8'd2, '0, 1'b1));
        add_row(CMD_TICK, 32'd0, 32'd0, 1'b0, 32'd0, 8'd0, 1, 0, 0, NO_RES);
        // elapsed wraps to all ones, one-shot at max period fires and frees
        add_row(CMD_TICK, 32'hFFFF_FFFE, 32'd0, 1'b0, 32'd0, 8'd0, 1, 0, 0, NO_RES);
        // fill the table, then overflow
        add_row(CMD_ARM, 32'd100, 32'd5, 1'b0, 32'hA5A5_0001, 8'd0, SLOTS - 1, 0, 0, NO_RES);
        add_row(CMD_ARM, 32'd100, 32'd5, 1'b1, 32'h1234_5678, 8'd0, 1, 1, 1,
                res_beat(KIND_ARM, ST_FULL, 8'd0, '0, 1'b1));
        add_row(CMD_TICK, 32'd104, 32'd0, 1'b0, 32'd0, 8'd0, 1, 0, 0, NO_RES);
        // every slot due at once
        add_row(CMD_TICK, 32'd105, 32'd0, 1'b0, 32'd0, 8'd0, 1, 0, 0, NO_RES);
        add_row(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 32'd0, 8'd16, 1, 1, 1,
                res_beat(KIND_CANCEL, ST_OK, 8'd16, '0, 1'b1));
        add_row(CMD_CANCEL, 32'd0, 32'd0, 1'b0, 32'd0, 8'd16, 1, 1, 1,
                res_beat(KIND_CANCEL, ST_OK, 8'd16, '0, 1'b1));
        add_row(CMD_ARM, 32'd200, 32'd1, 1'b1, 32'h5A5A_5A5A, 8'd0, 1, 1, 1,
                res_beat(KIND_ARM, ST_OK, 8'd16, '0, 1'b1));
        add_row(CMD_TICK, 32'd201, 32'd0, 1'b0, 32'd0, 8'd0, 1, 0, 0, NO_RES);

        tx_idle_pct = 15;
        rx_idle_pct = 62;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            for (int k = 0; k < dir_rows[r].reps; k++) begin
                b = dir_rows[r].beat;
                b.tag = b.tag + k;
                post_command(b, dir_rows[r].typed, dir_rows[r].n_typed, dir_rows[r].want);
            end
        end

        // random phases: sender-light, receiver-light, no idling
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 62 : 0;
            rx_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 15 : 0;
            tick_ms = $urandom_range(1) ? $urandom : 32'hFFFF_FF00 + $urandom_range(250);
            n = 0;
            while (n < RAND_ITEMS / 3) begin
                b = rand_command();
                post_command(b, 1'b0, 0, NO_RES);
                if (b.cmd != CMD_UNUSED) n++;
            end
        end
        i_s_tvalid <= 1'b0;

        // drain, then leave room for stray beats
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
